/* src/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants shared by the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

	localparam int WD_W  = 24;
	localparam int LEN_W = 16;

	typedef logic [2:0] action_t;

	localparam action_t ACT_MID       = 3'd0;
	localparam action_t ACT_OTHER     = 3'd1;
	localparam action_t ACT_NEED_DATA = 3'd2;
	localparam action_t ACT_PING      = 3'd3;
	localparam action_t ACT_BAD_ADDR  = 3'd4;
	localparam action_t ACT_WDOG      = 3'd5;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_WD_LIMIT  = 2'd0;
	localparam reg_idx_t REG_NEED_DATA = 2'd1;
	localparam reg_idx_t REG_PING      = 2'd2;

	localparam logic [WD_W-1:0] WD_LIMIT_RST  = 24'd10000;
	localparam logic [7:0]      NEED_DATA_RST = 8'd0;
	localparam logic [7:0]      PING_RST      = 8'd1;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       frame_address;
		logic [7:0]       frame_code;
		logic [LEN_W-1:0] payload_length;
		logic             has_byte;
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] byte_index;
		logic             last;
		action_t          action;
	} out_item_t;

	typedef struct packed {
		logic [WD_W-1:0] wd_limit;
		logic [7:0]      need_data_code;
		logic [7:0]      ping_code;
	} cfg_t;

endpackage

/* src/length_prefixed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Deframes address, code, 16-bit length and payload; watchdog on tick beats.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high, a received byte or a
// watchdog tick, and gives at most one result beat for it. A beat waits in the
// input register, where header, payload counter and watchdog are updated, and
// then lands in the output register; the sustained rate is one beat per cycle
// while the result side takes its beats. A stalled output register holds the
// input register, and the input side stalls only when both are full.
module length_prefixed_frame_receiver import lpfr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data,
	input  logic            cfg_we,
	input  reg_idx_t        cfg_index,
	input  logic [WD_W-1:0] cfg_wdata
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv;
	out_item_t res;
	logic      res_valid;
	logic      out_valid_q;
	out_item_t out_data_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wd_limit       <= WD_LIMIT_RST;
			cfg_q.need_data_code <= NEED_DATA_RST;
			cfg_q.ping_code      <= PING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WD_LIMIT:  cfg_q.wd_limit       <= cfg_wdata;
				REG_NEED_DATA: cfg_q.need_data_code <= cfg_wdata[7:0];
				REG_PING:      cfg_q.ping_code      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lpfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_last_marks_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.action != ACT_MID)))
		else $error("last and action disagree");

	a_wdog_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_WDOG |->
			out_data.frame_address == 8'd0 && out_data.frame_code == 8'd0 &&
			out_data.payload_length == '0 && !out_data.has_byte)
		else $error("watchdog result carries header data");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_byte |->
			out_data.payload_byte == 8'd0 && out_data.byte_index == '0)
		else $error("empty result carries byte data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");
`endif

endmodule

/* src/lpfr_parser.sv */
// ----------------------------------------------------------------------------
// lpfr_parser
// Frame header parser, payload counter and watchdog; one beat per step.
// ----------------------------------------------------------------------------
module lpfr_parser import lpfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res,
	output logic      res_valid
);

	logic [1:0]       hdr_pos_q, hdr_pos_d;
	logic             in_payload_q, in_payload_d;
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       code_q, code_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [WD_W-1:0]  wd_q, wd_d;

	logic [WD_W-1:0]  wd_inc;
	logic [LEN_W-1:0] count_inc;
	logic [LEN_W-1:0] new_len;
	action_t          frame_act;

	assign wd_inc    = wd_q + 1'b1;
	assign count_inc = count_q + 1'b1;
	assign new_len   = {len_q[LEN_W-1:8], item.rx_byte};

	always_comb begin
		if (addr_q != 8'd0) begin
			frame_act = ACT_BAD_ADDR;
		end else if (code_q == cfg.need_data_code) begin
			frame_act = ACT_NEED_DATA;
		end else if (code_q == cfg.ping_code) begin
			frame_act = ACT_PING;
		end else begin
			frame_act = ACT_OTHER;
		end
	end

	always_comb begin
		hdr_pos_d    = hdr_pos_q;
		in_payload_d = in_payload_q;
		addr_d       = addr_q;
		code_d       = code_q;
		len_d        = len_q;
		count_d      = count_q;
		wd_d         = wd_q;
		res          = '0;
		res_valid    = 1'b0;
		res.frame_address  = addr_q;
		res.frame_code     = code_q;
		res.payload_length = len_q;

		if (item.mode == MODE_TICK) begin
			wd_d = wd_inc;
			if (wd_inc >= cfg.wd_limit) begin
				hdr_pos_d    = 2'd0;
				in_payload_d = 1'b0;
				addr_d       = '0;
				code_d       = '0;
				len_d        = '0;
				count_d      = '0;
				wd_d         = '0;
				res          = '0;
				res.last     = 1'b1;
				res.action   = ACT_WDOG;
				res_valid    = 1'b1;
			end
		end else if (in_payload_q) begin
			count_d          = count_inc;
			res.has_byte     = 1'b1;
			res.payload_byte = item.rx_byte;
			res.byte_index   = count_q;
			res_valid        = 1'b1;
			if (count_inc >= len_q) begin
				res.last     = 1'b1;
				res.action   = frame_act;
				hdr_pos_d    = 2'd0;
				in_payload_d = 1'b0;
				count_d      = '0;
			end
		end else begin
			case (hdr_pos_q)
				2'd0: begin
					addr_d    = item.rx_byte;
					hdr_pos_d = 2'd1;
				end
				2'd1: begin
					code_d    = item.rx_byte;
					hdr_pos_d = 2'd2;
				end
				2'd2: begin
					len_d     = {item.rx_byte, 8'd0};
					hdr_pos_d = 2'd3;
				end
				default: begin
					len_d     = new_len;
					hdr_pos_d = 2'd0;
					count_d   = '0;
					if (new_len == '0) begin
						res.payload_length = new_len;
						res.last           = 1'b1;
						res.action         = frame_act;
						res_valid          = 1'b1;
					end else begin
						in_payload_d = 1'b1;
					end
				end
			endcase
		end

		if (res_valid && res.last) begin
			if (res.action == ACT_PING) begin
				wd_d = '0;
			end
			if (res.action == ACT_BAD_ADDR) begin
				addr_d = '0;
				code_d = '0;
				len_d  = '0;
				wd_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= 2'd0;
			in_payload_q <= 1'b0;
			addr_q       <= '0;
			code_q       <= '0;
			len_q        <= '0;
			count_q      <= '0;
			wd_q         <= '0;
		end else if (step) begin
			hdr_pos_q    <= hdr_pos_d;
			in_payload_q <= in_payload_d;
			addr_q       <= addr_d;
			code_q       <= code_d;
			len_q        <= len_d;
			count_q      <= count_d;
			wd_q         <= wd_d;
		end
	end

endmodule
